// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SUDIV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define SUDIV_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define SUDIV_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SUDIV_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== hw/rtl/sudiv_pkg.sv =====
`default_nettype none

package sudiv_pkg;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    // sign and special-case handling decided at the front
    typedef struct packed {
        logic neg_q;
        logic neg_r;
        logic zero_div;
    } cls_t;

endpackage

`default_nettype wire

// ===== hw/rtl/signed_unsigned_integer_divider_unit.sv =====
// done pulses after the front register, queue, restoring stages and output register
// throughput: one division per cycle, one restoring step per pipeline stage
// busy stays low in use, since the result side drains every cycle
// reset: rst_n clears all valid flags and queue pointers; data registers are not reset
`default_nettype none
`include "assert_macros.svh"

module signed_unsigned_integer_divider_unit #(
    parameter int DATA_WIDTH  = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  op,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      quotient,
    output logic [DATA_WIDTH-1:0]      remainder
);

    localparam int CLS_W   = $bits(sudiv_pkg::cls_t);
    localparam int WORD_W  = 2 * DATA_WIDTH + CLS_W;
    localparam int LATENCY = DATA_WIDTH + 4;

    logic                  fr_valid;
    logic                  fr_ready;
    logic [DATA_WIDTH-1:0] fr_mag_n;
    logic [DATA_WIDTH-1:0] fr_mag_d;
    sudiv_pkg::cls_t       fr_cls;

    logic                  bk_valid;
    logic [WORD_W-1:0]     bk_word;
    logic [DATA_WIDTH-1:0] bk_mag_n;
    logic [DATA_WIDTH-1:0] bk_mag_d;
    sudiv_pkg::cls_t       bk_cls;

    sudiv_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .dividend   (dividend),
        .divisor    (divisor),
        .word_valid (fr_valid),
        .word_ready (fr_ready),
        .mag_n      (fr_mag_n),
        .mag_d      (fr_mag_d),
        .cls        (fr_cls)
    );

    sudiv_fifo #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   ({fr_mag_n, fr_mag_d, fr_cls}),
        .out_valid (bk_valid),
        .out_data  (bk_word)
    );

    assign bk_mag_n = bk_word[WORD_W-1 -: DATA_WIDTH];
    assign bk_mag_d = bk_word[CLS_W +: DATA_WIDTH];
    assign bk_cls   = sudiv_pkg::cls_t'(bk_word[CLS_W-1:0]);

    sudiv_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bk_valid),
        .mag_n     (bk_mag_n),
        .mag_d     (bk_mag_d),
        .cls       (bk_cls),
        .done      (done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    `SUDIV_ASSERT_IMP(a_done_has_source, clk, rst_n, done, $past(start && !busy, LATENCY))
    `SUDIV_ASSERT_IMP(a_accept_gives_done, clk, rst_n, $past(start && !busy, LATENCY), done)
    `SUDIV_ASSERT_NEVER(a_never_busy, clk, rst_n, busy)

endmodule

`default_nettype wire

// ===== hw/rtl/sudiv_front.sv =====
`default_nettype none

module sudiv_front #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  op,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       word_valid,
    input  wire logic                  word_ready,
    output logic [DATA_WIDTH-1:0]      mag_n,
    output logic [DATA_WIDTH-1:0]      mag_d,
    output sudiv_pkg::cls_t            cls
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] mag_n_reg;
    logic [DATA_WIDTH-1:0] mag_d_reg;
    sudiv_pkg::cls_t       cls_reg;

    logic                  accept;
    logic                  is_signed;
    logic                  n_neg;
    logic                  d_neg;
    logic [DATA_WIDTH-1:0] mag_n_next;
    logic [DATA_WIDTH-1:0] mag_d_next;
    sudiv_pkg::cls_t       cls_next;

    assign busy   = valid_reg && !word_ready;
    assign accept = start && !busy;

    always_comb
    begin
        is_signed  = (op == sudiv_pkg::OP_SIGNED);
        n_neg      = is_signed && dividend[DATA_WIDTH-1];
        d_neg      = is_signed && divisor[DATA_WIDTH-1];
        mag_n_next = n_neg ? (~dividend + DATA_WIDTH'(1)) : dividend;
        mag_d_next = d_neg ? (~divisor + DATA_WIDTH'(1)) : divisor;
        cls_next.neg_q    = n_neg ^ d_neg;
        cls_next.neg_r    = n_neg;
        cls_next.zero_div = (divisor == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!busy)
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_n_reg <= mag_n_next;
            mag_d_reg <= mag_d_next;
            cls_reg   <= cls_next;
        end
    end

    assign word_valid = valid_reg;
    assign mag_n      = mag_n_reg;
    assign mag_d      = mag_d_reg;
    assign cls        = cls_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sudiv_fifo.sv =====
`default_nettype none

module sudiv_fifo #(
    parameter int WIDTH = 67,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    output logic [WIDTH-1:0]      out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;

    logic             push;
    logic             pop;

    // the back end never stalls, so a held word drains every cycle
    assign pop      = (count_reg != '0);
    assign in_ready = (count_reg != CNT_W'(DEPTH)) || pop;
    assign push     = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
        if (pop)
        begin
            out_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= pop;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sudiv_back.sv =====
`default_nettype none

module sudiv_back #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [DATA_WIDTH-1:0] mag_n,
    input  wire logic [DATA_WIDTH-1:0] mag_d,
    input  wire sudiv_pkg::cls_t       cls,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      quotient,
    output logic [DATA_WIDTH-1:0]      remainder
);

    localparam int W = DATA_WIDTH;

    // one restoring step per stage; a shifts dividend bits out and quotient bits in
    logic            v_reg   [W];
    logic [W-1:0]    r_reg   [W];
    logic [W-1:0]    a_reg   [W];
    logic [W-1:0]    d_reg   [W];
    sudiv_pkg::cls_t cls_reg [W];

    logic            done_reg;
    logic [W-1:0]    quotient_reg;
    logic [W-1:0]    remainder_reg;

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_step
            logic            v_prev;
            logic [W-1:0]    r_prev;
            logic [W-1:0]    a_prev;
            logic [W-1:0]    d_prev;
            sudiv_pkg::cls_t cls_prev;
            logic [W-1:0]    shifted;
            logic [W:0]      diff;
            logic            take;
            logic [W-1:0]    r_next;
            logic [W-1:0]    a_next;

            if (k == 0)
            begin : g_first
                assign v_prev   = in_valid;
                assign r_prev   = '0;
                assign a_prev   = mag_n;
                assign d_prev   = mag_d;
                assign cls_prev = cls;
            end
            else
            begin : g_rest
                assign v_prev   = v_reg[k-1];
                assign r_prev   = r_reg[k-1];
                assign a_prev   = a_reg[k-1];
                assign d_prev   = d_reg[k-1];
                assign cls_prev = cls_reg[k-1];
            end

            always_comb
            begin
                shifted = {r_prev[W-2:0], a_prev[W-1]};
                // top bit of the old remainder acts as a carry into the compare
                diff    = {r_prev[W-1], shifted} - {1'b0, d_prev};
                take    = r_prev[W-1] || !diff[W];
                r_next  = take ? diff[W-1:0] : shifted;
                a_next  = {a_prev[W-2:0], take};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else
                begin
                    v_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                r_reg[k]   <= r_next;
                a_reg[k]   <= a_next;
                d_reg[k]   <= d_prev;
                cls_reg[k] <= cls_prev;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_reg[W-1];
        end
    end

    // sign fix-up; a zero divisor gives a zero quotient and leaves the dividend in the remainder
    always_ff @(posedge clk)
    begin
        if (cls_reg[W-1].zero_div)
        begin
            quotient_reg <= '0;
        end
        else if (cls_reg[W-1].neg_q)
        begin
            quotient_reg <= ~a_reg[W-1] + W'(1);
        end
        else
        begin
            quotient_reg <= a_reg[W-1];
        end
        remainder_reg <= cls_reg[W-1].neg_r ? (~r_reg[W-1] + W'(1)) : r_reg[W-1];
    end

    assign done      = done_reg;
    assign quotient  = quotient_reg;
    assign remainder = remainder_reg;

endmodule

`default_nettype wire
